// ===== rtl/core/vbrt_pkg.sv =====
package vbrt_pkg;

   localparam int unsigned VAL_W      = 10;
   localparam int unsigned ROOT_W     = 13;
   localparam int unsigned SQRT_STEPS = 13;
   localparam int unsigned CNT_W      = 4;
   localparam int unsigned COORD_W    = 6;
   localparam int unsigned SQ_W       = 11;
   localparam int unsigned SUM_W      = 12;
   localparam int unsigned WIDE_W     = 17;

   localparam logic OP_BUILD = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic CSR_MAX_SQUARE = 1'b0;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_CLEAR,
      ST_MARK,
      ST_SCAN,
      ST_DRAIN,
      ST_Q_START,
      ST_Q_LOW,
      ST_Q_WAIT,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic capture;
      logic build_start;
      logic clear_step;
      logic mark_step;
      logic scan_step;
      logic query_start;
      logic query_low;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic is_build;
      logic out_of_range;
      logic walk_last;
      logic mark_last;
      logic roots_busy;
   } status_type;

endpackage

// ===== rtl/core/vbrt_sqrt.sv =====
module vbrt_sqrt
   import vbrt_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [VAL_W-1:0]  value,
   output logic              busy,
   output logic [ROOT_W-1:0] root
);

   localparam int unsigned RAD_W = VAL_W + 16;
   localparam int unsigned REM_W = ROOT_W + 1;

   logic [RAD_W-1:0]  rad_ff, rad_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic [REM_W+1:0]  rem_sh;
   logic [REM_W+1:0]  trial;

   always_comb begin
      rem_sh  = {rem_ff, rad_ff[RAD_W-1 -: 2]};
      trial   = {1'b0, root_ff, 2'b01};
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         rad_in  = {value, 16'd0};
         rem_in  = '0;
         root_in = '0;
         cnt_in  = CNT_W'(SQRT_STEPS - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in = {rad_ff[RAD_W-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = REM_W'(rem_sh - trial);
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = REM_W'(rem_sh);
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   assign busy = busy_ff;
   assign root = root_ff;

endmodule

// ===== rtl/core/vbrt_datapath.sv =====
module vbrt_datapath
   import vbrt_pkg::*;
#(
   parameter int unsigned TABLE_DEPTH = 1024
)
(
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output status_type        status,
   input  logic [VAL_W-1:0]  max_square,
   input  logic              req_op,
   input  logic [VAL_W-1:0]  req_distance_square,
   output logic              rsp_build_done,
   output logic              rsp_out_of_range,
   output logic [ROOT_W-1:0] rsp_distance_root,
   output logic [VAL_W-1:0]  rsp_lower_square,
   output logic [ROOT_W-1:0] rsp_lower_root
);

   localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam logic [WIDE_W-1:0] DEPTH_M1 = WIDE_W'(TABLE_DEPTH - 1);

   function automatic logic [AW-1:0] to_addr(input logic [SUM_W-1:0] v);
      logic [WIDE_W-1:0] w;
      w = WIDE_W'(v);
      return w[AW-1:0];
   endfunction

   logic               mask_mem [TABLE_DEPTH];
   logic [VAL_W-1:0]   table_mem [TABLE_DEPTH];

   logic               op_ff, op_in;
   logic [VAL_W-1:0]   n_ff, n_in;
   logic [VAL_W-1:0]   limit_ff, limit_in;
   logic [VAL_W-1:0]   walk_ff, walk_in;
   logic [COORD_W-1:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [SQ_W-1:0]    sx_ff, sx_in, sy_ff, sy_in, sz_ff, sz_in;
   logic [VAL_W-1:0]   prev_ff, prev_in;
   logic               rd_valid_ff;
   logic [VAL_W-1:0]   rd_idx_ff;
   logic               mask_rd_ff;
   logic [VAL_W-1:0]   table_rd_ff;
   logic               done_ff, oor_ff;
   logic [ROOT_W-1:0]  droot_ff, lroot_ff;
   logic [VAL_W-1:0]   lsq_ff;

   logic [SUM_W-1:0]   sum;
   logic               mark_fit;
   logic               oor;
   logic [VAL_W-1:0]   limit_clamped;
   logic               mask_we;
   logic [AW-1:0]      mask_waddr;
   logic               a_busy, b_busy;
   logic [ROOT_W-1:0]  a_root, b_root;

   assign sum      = SUM_W'(sx_ff) + SUM_W'(sy_ff) + SUM_W'(sz_ff);
   assign mark_fit = sum <= SUM_W'(limit_ff);
   assign oor      = n_ff > limit_ff;
   assign limit_clamped = (WIDE_W'(max_square) > DEPTH_M1) ? DEPTH_M1[VAL_W-1:0] : max_square;

   assign status.is_build     = (op_ff == OP_BUILD);
   assign status.out_of_range = oor;
   assign status.walk_last    = (walk_ff == limit_ff);
   assign status.mark_last    = !mark_fit && (y_ff == '0) && (z_ff == '0);
   assign status.roots_busy   = a_busy || b_busy;

   always_comb begin
      op_in    = op_ff;
      n_in     = n_ff;
      limit_in = limit_ff;
      walk_in  = walk_ff;
      x_in = x_ff;  y_in = y_ff;  z_in = z_ff;
      sx_in = sx_ff; sy_in = sy_ff; sz_in = sz_ff;
      prev_in  = prev_ff;
      if (cmd.capture) begin
         op_in = req_op;
         n_in  = req_distance_square;
      end
      if (cmd.build_start) begin
         limit_in = limit_clamped;
         walk_in  = '0;
         x_in = '0;  y_in = '0;  z_in = '0;
         sx_in = '0; sy_in = '0; sz_in = '0;
         prev_in  = '0;
      end
      if (cmd.clear_step || cmd.scan_step) begin
         walk_in = walk_ff + VAL_W'(1);
      end
      if (cmd.mark_step) begin
         if (mark_fit) begin
            z_in  = z_ff + COORD_W'(1);
            sz_in = sz_ff + SQ_W'({z_ff, 1'b1});
         end else if (z_ff != '0) begin
            z_in  = '0;
            sz_in = '0;
            y_in  = y_ff + COORD_W'(1);
            sy_in = sy_ff + SQ_W'({y_ff, 1'b1});
         end else if (y_ff != '0) begin
            y_in  = '0;
            sy_in = '0;
            x_in  = x_ff + COORD_W'(1);
            sx_in = sx_ff + SQ_W'({x_ff, 1'b1});
         end else begin
            walk_in = '0;
         end
      end
      if (rd_valid_ff && mask_rd_ff) begin
         prev_in = rd_idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
      n_ff  <= n_in;
      walk_ff <= walk_in;
      x_ff <= x_in;  y_ff <= y_in;  z_ff <= z_in;
      sx_ff <= sx_in; sy_ff <= sy_in; sz_ff <= sz_in;
      prev_ff <= prev_in;
      rd_idx_ff <= walk_ff;
      if (reset) begin
         limit_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         limit_ff    <= limit_in;
         rd_valid_ff <= cmd.scan_step;
      end
   end

   // occupancy bitmap
   assign mask_we    = cmd.clear_step || (cmd.mark_step && mark_fit);
   assign mask_waddr = cmd.clear_step ? to_addr(SUM_W'(walk_ff)) : to_addr(sum);

   always_ff @(posedge clock) begin
      if (mask_we) begin
         mask_mem[mask_waddr] <= cmd.mark_step;
      end
      mask_rd_ff <= mask_mem[to_addr(SUM_W'(walk_ff))];
   end

   // lower square table
   always_ff @(posedge clock) begin
      if (rd_valid_ff) begin
         table_mem[to_addr(SUM_W'(rd_idx_ff))] <= prev_ff;
      end
      table_rd_ff <= table_mem[to_addr(SUM_W'(n_ff))];
   end

   vbrt_sqrt u_root_dist (
      .clock (clock),
      .reset (reset),
      .start (cmd.query_start),
      .value (n_ff),
      .busy  (a_busy),
      .root  (a_root)
   );

   vbrt_sqrt u_root_low (
      .clock (clock),
      .reset (reset),
      .start (cmd.query_low),
      .value (table_rd_ff),
      .busy  (b_busy),
      .root  (b_root)
   );

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         done_ff  <= (op_ff == OP_BUILD);
         oor_ff   <= (op_ff == OP_QUERY) && oor;
         if ((op_ff == OP_BUILD) || oor) begin
            droot_ff <= '0;
            lsq_ff   <= '0;
            lroot_ff <= '0;
         end else begin
            droot_ff <= a_root;
            lsq_ff   <= table_rd_ff;
            lroot_ff <= b_root;
         end
      end
   end

   assign rsp_build_done    = done_ff;
   assign rsp_out_of_range  = oor_ff;
   assign rsp_distance_root = droot_ff;
   assign rsp_lower_square  = lsq_ff;
   assign rsp_lower_root    = lroot_ff;

endmodule

// ===== rtl/core/vbrt_ctrl.sv =====
module vbrt_ctrl
   import vbrt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      load_ok;

   assign load_ok = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (status.is_build) begin
               state_in = ST_CLEAR;
            end else if (status.out_of_range) begin
               state_in = ST_RESP;
            end else begin
               state_in = ST_Q_START;
            end
         end
         ST_CLEAR: begin
            if (status.walk_last) begin
               state_in = ST_MARK;
            end
         end
         ST_MARK: begin
            if (status.mark_last) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.walk_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN:   state_in = ST_RESP;
         ST_Q_START: state_in = ST_Q_LOW;
         ST_Q_LOW:   state_in = ST_Q_WAIT;
         ST_Q_WAIT: begin
            if (!status.roots_busy) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (load_ok) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         ST_DECODE:  cmd.build_start = status.is_build;
         ST_CLEAR:   cmd.clear_step  = 1'b1;
         ST_MARK:    cmd.mark_step   = 1'b1;
         ST_SCAN:    cmd.scan_step   = 1'b1;
         ST_Q_START: cmd.query_start = 1'b1;
         ST_Q_LOW:   cmd.query_low   = 1'b1;
         ST_RESP:    cmd.rsp_load    = load_ok;
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ===== rtl/core/voxel_ball_radius_table.sv =====
// Lower ball radius table. A build item (op 0) clears and refills an occupancy bitmap of
// every x*x+y*y+z*z up to max_square (clamped to TABLE_DEPTH-1), then fills the lower table,
// and answers with build_done set; it walks 0 to that limit for the clear and again for the
// table fill, and between them visits the lattice points of the octant ball of that radius.
// A query item (op 1) returns the Q5.8 floored roots of distance_square and of its table
// entry from two 13-step bit-serial root units, the second started in the cycle after the
// first so that it takes the registered table read. A query above the limit of the last
// build returns out_of_range without starting the root units. One item is in work at a
// time; a finished result waits in an output register while the next item is taken. Query
// before any build is undefined except above range.
module voxel_ball_radius_table
   import vbrt_pkg::*;
#(
   parameter int unsigned TABLE_DEPTH = 1024
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [9:0] distance_square
   input  logic [0:0]  req_tuser,   // [0] op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [12:0] distance_root, [22:13] lower_square,
                                    // [35:23] lower_root
   output logic [1:0]  rsp_tuser,   // [0] build_done, [1] out_of_range
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   cmd_type           cmd;
   status_type        status;
   logic [VAL_W-1:0]  max_square_ff, max_square_in;
   logic              rsp_build_done, rsp_out_of_range;
   logic [ROOT_W-1:0] rsp_distance_root, rsp_lower_root;
   logic [VAL_W-1:0]  rsp_lower_square;

   assign csr_pready = 1'b1;

   always_comb begin
      max_square_in = max_square_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready
          && (csr_paddr[2] == CSR_MAX_SQUARE)) begin
         max_square_in = csr_pwdata[VAL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_square_ff <= VAL_W'(1023);
      end else begin
         max_square_ff <= max_square_in;
      end
   end

   assign csr_prdata = (csr_paddr[2] == CSR_MAX_SQUARE) ? 32'(max_square_ff) : 32'd0;

   vbrt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   vbrt_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .max_square          (max_square_ff),
      .req_op              (req_tuser[0]),
      .req_distance_square (req_tdata[VAL_W-1:0]),
      .rsp_build_done      (rsp_build_done),
      .rsp_out_of_range    (rsp_out_of_range),
      .rsp_distance_root   (rsp_distance_root),
      .rsp_lower_square    (rsp_lower_square),
      .rsp_lower_root      (rsp_lower_root)
   );

   assign rsp_tdata = {4'd0, rsp_lower_root, rsp_lower_square, rsp_distance_root};
   assign rsp_tuser = {rsp_out_of_range, rsp_build_done};

endmodule

// ===== rtl/core/vbrt_checker.sv =====
module vbrt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second item taken while one is in work");

   a_build_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> (rsp_tdata == 40'd0) && !rsp_tuser[1])
      else $error("build result carries data");

   a_range_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> (rsp_tdata == 40'd0))
      else $error("out of range result carries data");

endmodule

bind voxel_ball_radius_table vbrt_checker u_vbrt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
